/* rtl/stq_pkg.sv */
package stq_pkg;

   localparam int CAPACITY_DEF  = 16;
   localparam int TIME_BITS_DEF = 32;
   localparam int ID_BITS_DEF   = 10;

   // Field widths of the request and response items
   localparam int OPCODE_W = 2;
   localparam int ID_W     = 10;
   localparam int TIME_W   = 32;
   localparam int STATUS_W = 3;

   typedef enum logic [OPCODE_W-1:0] {
      OP_ADD    = 2'd0,
      OP_ADJUST = 2'd1,
      OP_DELETE = 2'd2,
      OP_TICK   = 2'd3
   } opcode_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK        = 3'd0,
      ST_FULL      = 3'd1,
      ST_NOT_FOUND = 3'd2,
      ST_DUPLICATE = 3'd3,
      ST_NOTHING   = 3'd4
   } status_type;

   typedef struct packed {
      logic [OPCODE_W-1:0] opcode;
      logic [ID_W-1:0]     timer_id;
      logic [TIME_W-1:0]   expire_time;
      logic [TIME_W-1:0]   now_time;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [ID_W-1:0]     expired_id;
      logic                last;
   } rsp_type;

   // What a cell loads at the next edge
   typedef enum logic [1:0] {
      CMD_HOLD       = 2'd0,
      CMD_LOAD       = 2'd1,
      CMD_FROM_LEFT  = 2'd2,
      CMD_FROM_RIGHT = 2'd3
   } cell_cmd_type;

   // Per-cell compare results against the current key
   typedef struct packed {
      logic le;
      logic hit;
   } cell_flag_type;

endpackage

/* rtl/stq_cell.sv */
module stq_cell #(
   parameter int TIME_BITS = stq_pkg::TIME_BITS_DEF,
   parameter int ID_BITS   = stq_pkg::ID_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  stq_pkg::cell_cmd_type cmd,
   input  logic [TIME_BITS-1:0] key_time,
   input  logic [ID_BITS-1:0]   key_id,
   input  logic                 left_valid,
   input  logic [TIME_BITS-1:0] left_time,
   input  logic [ID_BITS-1:0]   left_id,
   input  logic                 right_valid,
   input  logic [TIME_BITS-1:0] right_time,
   input  logic [ID_BITS-1:0]   right_id,
   output logic                 slot_valid,
   output logic [TIME_BITS-1:0] slot_time,
   output logic [ID_BITS-1:0]   slot_id,
   output stq_pkg::cell_flag_type flags
);
   import stq_pkg::*;

   logic                 valid_ff, valid_in;
   logic [TIME_BITS-1:0] time_ff, time_in;
   logic [ID_BITS-1:0]   id_ff, id_in;

   always_comb begin
      case (cmd)
         CMD_LOAD: begin
            valid_in = 1'b1;
            time_in  = key_time;
            id_in    = key_id;
         end
         CMD_FROM_LEFT: begin
            valid_in = left_valid;
            time_in  = left_time;
            id_in    = left_id;
         end
         CMD_FROM_RIGHT: begin
            valid_in = right_valid;
            time_in  = right_time;
            id_in    = right_id;
         end
         default: begin
            valid_in = valid_ff;
            time_in  = time_ff;
            id_in    = id_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      time_ff <= time_in;
      id_ff   <= id_in;
   end

   assign flags.le    = valid_ff && (time_ff <= key_time);
   assign flags.hit   = valid_ff && (id_ff == key_id);
   assign slot_valid  = valid_ff;
   assign slot_time   = time_ff;
   assign slot_id     = id_ff;

endmodule

/* rtl/sorted_timer_queue_top.sv */
// Sorted timer queue: up to CAPACITY timers held in a row of cells in
// ascending order of expiry, the earliest in cell 0, addressed by timer id.
// Request channel: an item (req_data) is taken at an edge where start is
// high and busy is low. Ops: add, adjust expiry, delete, tick.
// Response channel: each result sits on rsp_data for one cycle with
// rsp_strobe high; the receiver cannot hold results off. Every op ends with
// a result that has last set.
// Timing: the item is registered on accept and worked in the next cycle;
// its result is registered and shows in the cycle after that. Adjust works
// as a remove pass, then an insert pass. Tick gives one expired id per
// cycle as cell 0 pops and the row shifts down, or one nothing result.
// Each step is one parallel compare in every cell plus at most one shift of
// part or all of the row, so the op count, not the queue depth, sets time.
// Reset (synchronous) empties the queue and drops any op in progress; the
// block is ready in the cycle after reset falls.
module sorted_timer_queue_top #(
   parameter int CAPACITY  = stq_pkg::CAPACITY_DEF,
   parameter int TIME_BITS = stq_pkg::TIME_BITS_DEF,
   parameter int ID_BITS   = stq_pkg::ID_BITS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  stq_pkg::req_type req_data,
   output logic             rsp_strobe,
   output stq_pkg::rsp_type rsp_data
);
   import stq_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE  = 3'b001,
      S_EXEC  = 3'b010,
      S_REINS = 3'b100
   } state_type;

   state_type            state_ff, state_in;
   opcode_type           op_ff;
   logic [TIME_BITS-1:0] key_time_ff, key_time_in;
   logic [ID_BITS-1:0]   key_id_ff;
   logic                 rsp_strobe_ff, rsp_strobe_in;
   rsp_type              rsp_ff, rsp_in;

   logic                 cell_valid [CAPACITY];
   logic [TIME_BITS-1:0] cell_time  [CAPACITY];
   logic [ID_BITS-1:0]   cell_id    [CAPACITY];
   cell_flag_type        cell_flags [CAPACITY];
   cell_cmd_type         cell_cmd   [CAPACITY];

   logic [CAPACITY-1:0]  le_vec, hit_vec, le_left, hit_pre, vld_vec;
   logic                 any_hit, full;
   logic                 do_insert, do_remove, do_pop;
   logic                 accept;

   assign accept = start && !busy;
   assign busy   = (state_ff != S_IDLE);

   always_comb begin
      for (int i = 0; i < CAPACITY; i++) begin
         le_vec[i]  = cell_flags[i].le;
         hit_vec[i] = cell_flags[i].hit;
         vld_vec[i] = cell_valid[i];
      end
   end

   assign le_left = {le_vec[CAPACITY-2:0], 1'b1};
   assign any_hit = |hit_vec;
   assign full    = cell_valid[CAPACITY-1];

   // Mark the hit cell and every cell above it
   always_comb begin
      hit_pre = hit_vec;
      for (int s = 1; s < CAPACITY; s = s * 2) begin
         hit_pre = hit_pre | (hit_pre << s);
      end
   end

   // Per-cell command
   always_comb begin
      for (int i = 0; i < CAPACITY; i++) begin
         if (do_pop) begin
            cell_cmd[i] = CMD_FROM_RIGHT;
         end else if (do_remove) begin
            cell_cmd[i] = hit_pre[i] ? CMD_FROM_RIGHT : CMD_HOLD;
         end else if (do_insert && !le_vec[i]) begin
            cell_cmd[i] = le_left[i] ? CMD_LOAD : CMD_FROM_LEFT;
         end else begin
            cell_cmd[i] = CMD_HOLD;
         end
      end
   end

   for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
      logic                 lv, rv;
      logic [TIME_BITS-1:0] lt, rt;
      logic [ID_BITS-1:0]   li, ri;

      if (g == 0) begin : g_first
         assign lv = 1'b0;
         assign lt = '0;
         assign li = '0;
      end else begin : g_mid_l
         assign lv = cell_valid[g-1];
         assign lt = cell_time[g-1];
         assign li = cell_id[g-1];
      end

      if (g == CAPACITY-1) begin : g_last
         assign rv = 1'b0;
         assign rt = '0;
         assign ri = '0;
      end else begin : g_mid_r
         assign rv = cell_valid[g+1];
         assign rt = cell_time[g+1];
         assign ri = cell_id[g+1];
      end

      stq_cell #(
         .TIME_BITS(TIME_BITS),
         .ID_BITS  (ID_BITS)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .cmd        (cell_cmd[g]),
         .key_time   (key_time_ff),
         .key_id     (key_id_ff),
         .left_valid (lv),
         .left_time  (lt),
         .left_id    (li),
         .right_valid(rv),
         .right_time (rt),
         .right_id   (ri),
         .slot_valid (cell_valid[g]),
         .slot_time  (cell_time[g]),
         .slot_id    (cell_id[g]),
         .flags      (cell_flags[g])
      );
   end

   assign key_time_in = (opcode_type'(req_data.opcode) == OP_TICK) ?
                        TIME_BITS'(req_data.now_time) : TIME_BITS'(req_data.expire_time);

   always_comb begin
      state_in      = state_ff;
      do_insert     = 1'b0;
      do_remove     = 1'b0;
      do_pop        = 1'b0;
      rsp_strobe_in = 1'b0;
      rsp_in        = '{status: ST_OK, expired_id: '0, last: 1'b1};
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            rsp_strobe_in = 1'b1;
            state_in      = S_IDLE;
            unique case (op_ff)
               OP_ADD: begin
                  if (any_hit) begin
                     rsp_in.status = ST_DUPLICATE;
                  end else if (full) begin
                     rsp_in.status = ST_FULL;
                  end else begin
                     do_insert = 1'b1;
                  end
               end
               OP_DELETE: begin
                  if (!any_hit) begin
                     rsp_in.status = ST_NOT_FOUND;
                  end else begin
                     do_remove = 1'b1;
                  end
               end
               OP_ADJUST: begin
                  if (!any_hit) begin
                     rsp_in.status = ST_NOT_FOUND;
                  end else begin
                     // drop the old entry now, reinsert next cycle
                     do_remove     = 1'b1;
                     rsp_strobe_in = 1'b0;
                     state_in      = S_REINS;
                  end
               end
               OP_TICK: begin
                  if (le_vec[0]) begin
                     do_pop            = 1'b1;
                     rsp_in.expired_id = ID_W'(cell_id[0]);
                     rsp_in.last       = !le_vec[1];
                     if (le_vec[1]) begin
                        state_in = S_EXEC;
                     end
                  end else begin
                     rsp_in.status = ST_NOTHING;
                  end
               end
               default: begin
                  rsp_strobe_in = 1'b0;
               end
            endcase
         end
         S_REINS: begin
            do_insert     = 1'b1;
            rsp_strobe_in = 1'b1;
            state_in      = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
      if (accept) begin
         op_ff       <= opcode_type'(req_data.opcode);
         key_time_ff <= key_time_in;
         key_id_ff   <= ID_BITS'(req_data.timer_id);
      end
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

   // Occupied cells always form a contiguous run from cell 0
   a_valid_packed: assert property (@(posedge clock) disable iff (reset)
      ((vld_vec & (vld_vec + CAPACITY'(1))) == '0))
      else $error("occupied cells not contiguous");

   a_accept_exec: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == S_EXEC))
      else $error("accepted item not worked next cycle");

   a_error_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && (rsp_data.status != ST_OK)) |-> rsp_data.last)
      else $error("refused item without last");

   a_tick_continues: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_data.last) |-> busy)
      else $error("tick stopped before its last result");

endmodule
